// File: sv/smiu_pkg.sv
// Shared types, sizes, opcodes and width helpers for the stack machine instruction unit.
package smiu_pkg;

  // Sizes
  localparam int DATA_DEPTH   = 256;
  localparam int RETURN_DEPTH = 64;
  localparam int WORD_BITS    = 32;
  localparam int PC_BITS      = 16;

  localparam int DADDR_BITS   = $clog2(DATA_DEPTH);
  localparam int DCNT_BITS    = $clog2(DATA_DEPTH + 1);
  localparam int RADDR_BITS   = $clog2(RETURN_DEPTH);
  localparam int RCNT_BITS    = $clog2(RETURN_DEPTH + 1);
  localparam int DIV_CNT_BITS = $clog2(WORD_BITS + 1);

  typedef logic [WORD_BITS-1:0]    word_t;
  typedef logic [PC_BITS-1:0]      pc_t;
  typedef logic [DADDR_BITS-1:0]   daddr_t;
  typedef logic [DCNT_BITS-1:0]    dcnt_t;
  typedef logic [RADDR_BITS-1:0]   raddr_t;
  typedef logic [RCNT_BITS-1:0]    rcnt_t;
  typedef logic [DIV_CNT_BITS-1:0] div_cnt_t;

  localparam dcnt_t DCNT_ONE  = dcnt_t'(1);
  localparam dcnt_t DCNT_TWO  = dcnt_t'(2);
  localparam dcnt_t DCNT_FULL = dcnt_t'(DATA_DEPTH);
  localparam rcnt_t RCNT_ONE  = rcnt_t'(1);
  localparam rcnt_t RCNT_FULL = rcnt_t'(RETURN_DEPTH);

  // Opcodes
  typedef enum logic [4:0] {
    OP_UNDEF = 5'd0,
    OP_RET   = 5'd1,
    OP_CALL  = 5'd2,
    OP_JMP   = 5'd3,
    OP_JEQ   = 5'd4,
    OP_JNE   = 5'd5,
    OP_JA    = 5'd6,
    OP_JAE   = 5'd7,
    OP_JB    = 5'd8,
    OP_JBE   = 5'd9,
    OP_PUSH  = 5'd10,
    OP_POP   = 5'd11,
    OP_ADD   = 5'd12,
    OP_SUB   = 5'd13,
    OP_MUL   = 5'd14,
    OP_DIV   = 5'd15,
    OP_OUT   = 5'd16,
    OP_IN    = 5'd17
  } op_t;

  // Status codes
  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_DUNDERFLOW = 3'd1,
    STAT_DOVERFLOW  = 3'd2,
    STAT_RUNDERFLOW = 3'd3,
    STAT_ROVERFLOW  = 3'd4,
    STAT_DIVZERO    = 3'd5,
    STAT_UNDEFINED  = 3'd6
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic        [4:0]  req_type;
    logic signed [31:0] operand;
    logic        [15:0] current_pc;
    logic signed [31:0] in_value;
  } req_t;

  typedef struct packed {
    logic        [15:0] next_pc;
    logic               pc_written;
    logic               out_valid;
    logic signed [31:0] out_word;
    logic        [2:0]  status;
    logic        [6:0]  call_depth;
  } rsp_t;

  // 32-bit input word, sign-extended, then cut to the stack word
  function automatic word_t word_from_in(logic [31:0] v);
    logic [63:0] t;
    t = {{32{v[31]}}, v};
    return t[WORD_BITS-1:0];
  endfunction

  // Stack word to the 32-bit output field (zero-extend or truncate)
  function automatic logic [31:0] word_to_out(word_t w);
    logic [63:0] t;
    t = 64'(w);
    return t[31:0];
  endfunction

  function automatic pc_t pc_from_operand(logic [31:0] v);
    logic [63:0] t;
    t = {32'd0, v};
    return t[PC_BITS-1:0];
  endfunction

  function automatic pc_t pc_from_in(logic [15:0] v);
    logic [63:0] t;
    t = {48'd0, v};
    return t[PC_BITS-1:0];
  endfunction

  function automatic logic [15:0] pc_to_out(pc_t p);
    logic [63:0] t;
    t = 64'(p);
    return t[15:0];
  endfunction

  function automatic logic [6:0] depth_to_out(rcnt_t c);
    logic [63:0] t;
    t = 64'(c);
    return t[6:0];
  endfunction

endpackage

// File: sv/smiu_div.sv
// Restoring divider, one quotient bit per cycle, truncating signed quotient.
module smiu_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  smiu_pkg::word_t      dividend,
  input  smiu_pkg::word_t      divisor,
  output logic                 done,
  output smiu_pkg::word_t      quotient
);

  logic                  run;
  smiu_pkg::div_cnt_t    cnt;
  logic                  neg;
  smiu_pkg::word_t       rem;
  smiu_pkg::word_t       quo;
  smiu_pkg::word_t       dvs;

  logic [smiu_pkg::WORD_BITS:0] shifted;
  logic                         fits;
  smiu_pkg::word_t              mag_a;
  smiu_pkg::word_t              mag_b;

  // Magnitudes of the operands
  assign mag_a = dividend[smiu_pkg::WORD_BITS-1] ? (~dividend + 1'b1) : dividend;
  assign mag_b = divisor[smiu_pkg::WORD_BITS-1]  ? (~divisor + 1'b1)  : divisor;

  // One trial subtraction
  assign shifted = {rem, quo[smiu_pkg::WORD_BITS-1]};
  assign fits    = shifted >= {1'b0, dvs};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      run <= 1'b1;
      cnt <= smiu_pkg::div_cnt_t'(smiu_pkg::WORD_BITS);
    end else if (run) begin
      if (cnt == '0) begin
        run <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= mag_a;
      dvs <= mag_b;
      neg <= dividend[smiu_pkg::WORD_BITS-1] ^ divisor[smiu_pkg::WORD_BITS-1];
    end else if (run && cnt != '0) begin
      rem <= fits ? smiu_pkg::word_t'(shifted - {1'b0, dvs})
                  : smiu_pkg::word_t'(shifted);
      quo <= {quo[smiu_pkg::WORD_BITS-2:0], fits};
    end
  end

  assign done     = run && (cnt == '0);
  assign quotient = neg ? (~quo + 1'b1) : quo;

endmodule

// File: sv/stack_machine_instruction_unit.sv
// Stack machine instruction unit: top level with stack memories and sequencer.
// Executes one stack-machine instruction per request transfer and returns one
// response. The data stack and the return stack live in synchronous RAMs; the
// top two data words and the top return address are read when a request is
// taken and the update is written back on commit. Most instructions are
// accepted, then executed and written back, or held until the output register
// is free; mul has its product registered in the held update before write-back;
// div waits for the one-bit-per-cycle divider. A finished response waits in an
// output register, so the next request can be taken while it is pending. Errors
// leave both stacks untouched and report a status code.
module stack_machine_instruction_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  smiu_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output smiu_pkg::rsp_t  rsp
);

  typedef struct packed {
    logic                   dwe;
    smiu_pkg::word_t        dval;
    smiu_pkg::dcnt_t        dcnt;
    logic                   rwe;
    smiu_pkg::rcnt_t        rcnt;
    smiu_pkg::rsp_t         rsp;
  } pend_t;

  smiu_pkg::state_t  state;
  smiu_pkg::state_t  state_next;

  smiu_pkg::req_t    req_q;
  smiu_pkg::dcnt_t   data_count;
  smiu_pkg::rcnt_t   return_count;

  smiu_pkg::word_t   data_mem [smiu_pkg::DATA_DEPTH];
  smiu_pkg::pc_t     ret_mem  [smiu_pkg::RETURN_DEPTH];
  smiu_pkg::word_t   top_a;
  smiu_pkg::word_t   top_b;
  smiu_pkg::pc_t     ret_top;

  pend_t             ex;
  pend_t             pend;
  pend_t             cm;
  logic              ex_div;
  logic              ex_mul;

  logic              accept;
  logic              commit;
  logic              load_pend;
  logic              div_start;
  logic              div_done;
  smiu_pkg::word_t   div_q;
  logic              slot_free;

  smiu_pkg::pc_t     cur_pc;
  smiu_pkg::pc_t     target;
  smiu_pkg::pc_t     nxt;
  logic              take;
  logic              written;
  logic              ovalid;
  logic [31:0]       oword;
  smiu_pkg::status_t status;
  smiu_pkg::word_t   prod;
  logic              a_eq_b;
  logic              a_lt_b;
  logic              b_lt_a;

  assign accept    = req_valid && req_ready;
  assign slot_free = !rsp_valid || rsp_ready;

  // Divider
  smiu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (top_a),
    .divisor  (top_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // Stack RAMs: read tops on transfer, write back on commit
  always_ff @(posedge clk) begin
    if (accept) begin
      top_a   <= data_mem[smiu_pkg::daddr_t'(data_count - smiu_pkg::DCNT_ONE)];
      top_b   <= data_mem[smiu_pkg::daddr_t'(data_count - smiu_pkg::DCNT_TWO)];
      ret_top <= ret_mem[smiu_pkg::raddr_t'(return_count - smiu_pkg::RCNT_ONE)];
    end
    if (commit && cm.dwe) begin
      data_mem[smiu_pkg::daddr_t'(data_count)] <= cm.dval;
    end
    if (commit && cm.rwe) begin
      ret_mem[smiu_pkg::raddr_t'(return_count)] <= cur_pc;
    end
  end

  // Compare and multiply on the registered tops
  assign a_eq_b = top_a == top_b;
  assign a_lt_b = $signed(top_a) < $signed(top_b);
  assign b_lt_a = $signed(top_b) < $signed(top_a);
  assign prod   = top_a * top_b;

  // Execute: decode, check, build the update
  always_comb begin
    cur_pc  = smiu_pkg::pc_from_in(req_q.current_pc);
    target  = smiu_pkg::pc_from_operand(req_q.operand);
    nxt     = cur_pc;
    written = 1'b0;
    ovalid  = 1'b0;
    oword   = '0;
    status  = smiu_pkg::STAT_OK;
    take    = 1'b0;
    ex_div  = 1'b0;
    ex_mul  = 1'b0;
    ex.dwe  = 1'b0;
    ex.dval = '0;
    ex.dcnt = data_count;
    ex.rwe  = 1'b0;
    ex.rcnt = return_count;

    unique case (req_q.req_type)
      smiu_pkg::OP_JEQ, smiu_pkg::OP_JNE, smiu_pkg::OP_JA,
      smiu_pkg::OP_JAE, smiu_pkg::OP_JB, smiu_pkg::OP_JBE: begin
        if (data_count < smiu_pkg::DCNT_TWO) begin
          status = smiu_pkg::STAT_DUNDERFLOW;
        end else begin
          unique case (req_q.req_type)
            smiu_pkg::OP_JEQ: take = a_eq_b;
            smiu_pkg::OP_JNE: take = !a_eq_b;
            smiu_pkg::OP_JA:  take = b_lt_a;
            smiu_pkg::OP_JAE: take = !a_lt_b;
            smiu_pkg::OP_JB:  take = a_lt_b;
            default:          take = !b_lt_a;
          endcase
          if (take) begin
            nxt     = target;
            written = 1'b1;
          end
        end
      end
      smiu_pkg::OP_ADD, smiu_pkg::OP_SUB, smiu_pkg::OP_MUL, smiu_pkg::OP_DIV: begin
        if (data_count < smiu_pkg::DCNT_TWO) begin
          status = smiu_pkg::STAT_DUNDERFLOW;
        end else if (data_count == smiu_pkg::DCNT_FULL) begin
          status = smiu_pkg::STAT_DOVERFLOW;
        end else if (req_q.req_type == smiu_pkg::OP_DIV && top_b == '0) begin
          status = smiu_pkg::STAT_DIVZERO;
        end else begin
          ex.dwe  = 1'b1;
          ex.dcnt = data_count + smiu_pkg::DCNT_ONE;
          unique case (req_q.req_type)
            smiu_pkg::OP_ADD: ex.dval = top_a + top_b;
            smiu_pkg::OP_SUB: ex.dval = top_a - top_b;
            smiu_pkg::OP_MUL: begin
              ex.dval = prod;
              ex_mul  = 1'b1;
            end
            default: ex_div = 1'b1;
          endcase
        end
      end
      smiu_pkg::OP_RET: begin
        if (return_count == '0) begin
          status = smiu_pkg::STAT_RUNDERFLOW;
        end else begin
          ex.rcnt = return_count - smiu_pkg::RCNT_ONE;
          nxt     = ret_top;
          written = 1'b1;
        end
      end
      smiu_pkg::OP_CALL: begin
        if (return_count == smiu_pkg::RCNT_FULL) begin
          status = smiu_pkg::STAT_ROVERFLOW;
        end else begin
          ex.rwe  = 1'b1;
          ex.rcnt = return_count + smiu_pkg::RCNT_ONE;
          nxt     = target;
          written = 1'b1;
        end
      end
      smiu_pkg::OP_JMP: begin
        nxt     = target;
        written = 1'b1;
      end
      smiu_pkg::OP_PUSH, smiu_pkg::OP_IN: begin
        if (data_count == smiu_pkg::DCNT_FULL) begin
          status = smiu_pkg::STAT_DOVERFLOW;
        end else begin
          ex.dwe  = 1'b1;
          ex.dcnt = data_count + smiu_pkg::DCNT_ONE;
          ex.dval = smiu_pkg::word_from_in((req_q.req_type == smiu_pkg::OP_PUSH) ?
                                           req_q.operand : req_q.in_value);
        end
      end
      smiu_pkg::OP_POP, smiu_pkg::OP_OUT: begin
        if (data_count == '0) begin
          status = smiu_pkg::STAT_DUNDERFLOW;
        end else begin
          ex.dcnt = data_count - smiu_pkg::DCNT_ONE;
          if (req_q.req_type == smiu_pkg::OP_OUT) begin
            ovalid = 1'b1;
            oword  = smiu_pkg::word_to_out(top_a);
          end
        end
      end
      default: status = smiu_pkg::STAT_UNDEFINED;
    endcase

    ex.rsp.next_pc    = smiu_pkg::pc_to_out(nxt);
    ex.rsp.pc_written = written;
    ex.rsp.out_valid  = ovalid;
    ex.rsp.out_word   = oword;
    ex.rsp.status     = status;
    ex.rsp.call_depth = smiu_pkg::depth_to_out(ex.rcnt);
  end

  // Update that gets committed: straight from execute, or the held one
  assign cm = (state == smiu_pkg::S_EXEC) ? ex : pend;

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smiu_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state and controls
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    commit     = 1'b0;
    load_pend  = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      smiu_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = smiu_pkg::S_EXEC;
        end
      end
      smiu_pkg::S_EXEC: begin
        if (ex_div) begin
          div_start  = 1'b1;
          load_pend  = 1'b1;
          state_next = smiu_pkg::S_DIV;
        end else if (ex_mul || !slot_free) begin
          load_pend  = 1'b1;
          state_next = smiu_pkg::S_COMMIT;
        end else begin
          commit     = 1'b1;
          state_next = smiu_pkg::S_IDLE;
        end
      end
      smiu_pkg::S_DIV: begin
        if (div_done) begin
          state_next = smiu_pkg::S_COMMIT;
        end
      end
      smiu_pkg::S_COMMIT: begin
        if (slot_free) begin
          commit     = 1'b1;
          state_next = smiu_pkg::S_IDLE;
        end
      end
      default: state_next = smiu_pkg::S_IDLE;
    endcase
  end

  // Request, held update and response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (load_pend) begin
      pend <= ex;
    end else if (state == smiu_pkg::S_DIV && div_done) begin
      pend.dval <= div_q;
    end
    if (commit) begin
      rsp <= cm.rsp;
    end
  end

  // Stack counts and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      data_count   <= '0;
      return_count <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (commit) begin
        data_count   <= cm.dcnt;
        return_count <= cm.rcnt;
        rsp_valid    <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid    <= 1'b0;
      end
    end
  end

endmodule
